// ----- sv/orth_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orth_pkg: shared types and constants
// Fixed-point formats, arctangent table and rounding helpers for the
// orthographic projection pipeline.
// ----------------------------------------------------------------------------
package orth_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int ANG_BITS    = 24;
	localparam int ANG_SHIFT   = ANG_BITS - FRAC_BITS;
	localparam int CORDIC_N    = 20;
	localparam int RED_W       = 36;
	localparam int ANGLE_W     = 33;
	localparam int TRIG_W      = 32;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 25;
	localparam int OUT_W       = 21;
	localparam int NUM_W       = 58;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_LAT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_LON = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_X   = 8'd3;

	localparam logic [20:0] SCALE_RESET = 21'd65536;

	// angle constants in degrees * 2^ANG_BITS
	localparam logic signed [RED_W-1:0] DEG_90  = RED_W'(90)  <<< ANG_BITS;
	localparam logic signed [RED_W-1:0] DEG_180 = RED_W'(180) <<< ANG_BITS;
	localparam logic signed [RED_W-1:0] DEG_360 = RED_W'(360) <<< ANG_BITS;
	localparam logic signed [RED_W-1:0] DEG_540 = RED_W'(540) <<< ANG_BITS;

	// 1/gain in Q30
	localparam logic signed [TRIG_W-1:0] CORDIC_START = 32'sd652032874;

	localparam logic signed [NUM_W-1:0] NUM_ONE  = NUM_W'(1) <<< (FRAC_BITS + 30);
	localparam logic signed [NUM_W-1:0] NUM_HALF = NUM_W'(1) <<< 30;
	localparam logic signed [NUM_W-1:0] OUT_MAX  = (NUM_W'(1) <<< (OUT_W - 1)) - NUM_W'(1);
	localparam logic signed [NUM_W-1:0] OUT_MIN  = -(NUM_W'(1) <<< (OUT_W - 1));

	typedef struct packed {
		logic signed [TRIG_W-1:0]  x;
		logic signed [TRIG_W-1:0]  y;
		logic signed [ANGLE_W-1:0] m;
		logic                      neg;
	} cordic_lane_t;

	// arctangent per iteration, degrees * 2^24
	function automatic logic signed [ANGLE_W-1:0] atan_deg(input int i);
		logic signed [ANGLE_W-1:0] r;
		unique case (i)
			0:  r = 33'sd754974720;
			1:  r = 33'sd445687602;
			2:  r = 33'sd235489088;
			3:  r = 33'sd119537938;
			4:  r = 33'sd60000934;
			5:  r = 33'sd30029717;
			6:  r = 33'sd15018523;
			7:  r = 33'sd7509720;
			8:  r = 33'sd3754917;
			9:  r = 33'sd1877466;
			10: r = 33'sd938734;
			11: r = 33'sd469367;
			12: r = 33'sd234684;
			13: r = 33'sd117342;
			14: r = 33'sd58671;
			15: r = 33'sd29335;
			16: r = 33'sd14668;
			17: r = 33'sd7334;
			18: r = 33'sd3667;
			default: r = 33'sd1833;
		endcase
		return r;
	endfunction

	// Q30 product with round to nearest
	function automatic logic signed [TRIG_W-1:0] mulq(
		input logic signed [TRIG_W-1:0] a,
		input logic signed [TRIG_W-1:0] b
	);
		logic signed [2*TRIG_W-1:0] p;
		p = (64'(a) * 64'(b)) + (64'sd1 <<< 29);
		return TRIG_W'(p >>> 30);
	endfunction

	// final rounding, saturation to the output width
	function automatic logic [OUT_W-1:0] pack_out(input logic signed [NUM_W-1:0] num);
		logic signed [NUM_W-1:0] v;
		v = (num + NUM_HALF) >>> 31;
		if (v > OUT_MAX)
			v = OUT_MAX;
		else if (v < OUT_MIN)
			v = OUT_MIN;
		return v[OUT_W-1:0];
	endfunction

endpackage

// ----- sv/orth_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orth_ifs: channel interfaces
// Point input, projected output and register write channels.
// ----------------------------------------------------------------------------
interface orth_point_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] lat;
	logic signed [25:0] lon;
	modport source (output valid, lat, lon, input ready);
	modport sink (input valid, lat, lon, output ready);
endinterface

interface orth_proj_if;
	logic               valid;
	logic               ready;
	logic signed [20:0] x_pos;
	logic signed [20:0] y_pos;
	logic               visible;
	modport source (output valid, x_pos, y_pos, visible, input ready);
	modport sink (input valid, x_pos, y_pos, visible, output ready);
endinterface

interface orth_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [24:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/orth_reduce.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orth_reduce: angle range reduction
// Wraps an angle to [-180,180) degrees, folds it into [-90,90] with a
// negate flag, and loads the CORDIC start vector. One registered stage.
// ----------------------------------------------------------------------------
module orth_reduce
	import orth_pkg::*;
(
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [RED_W-1:0] angle,
	output cordic_lane_t            lane_q
);

	logic signed [RED_W-1:0] wrap;
	logic signed [RED_W-1:0] fold;
	logic                    neg;

	// wrap by one or two whole turns, input stays within [-900,900) degrees
	always_comb begin
		priority if (angle >= DEG_540)
			wrap = angle - (DEG_360 <<< 1);
		else if (angle >= DEG_180)
			wrap = angle - DEG_360;
		else if (angle < -DEG_540)
			wrap = angle + (DEG_360 <<< 1);
		else if (angle < -DEG_180)
			wrap = angle + DEG_360;
		else
			wrap = angle;
	end

	// fold outer quadrants onto inner ones
	always_comb begin
		priority if (wrap > DEG_90) begin
			fold = wrap - DEG_180;
			neg  = 1'b1;
		end else if (wrap < -DEG_90) begin
			fold = wrap + DEG_180;
			neg  = 1'b1;
		end else begin
			fold = wrap;
			neg  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q.x   <= CORDIC_START;
			lane_q.y   <= '0;
			lane_q.m   <= fold[ANGLE_W-1:0];
			lane_q.neg <= neg;
		end
	end

endmodule

// ----- sv/orth_cordic_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orth_cordic_cell: one rotation-mode CORDIC iteration
// Rotates the vector by the fixed micro-angle of its stage and registers
// the result for the next cell.
// ----------------------------------------------------------------------------
module orth_cordic_cell
	import orth_pkg::*;
#(
	parameter int STAGE = 0
) (
	input  logic         clk,
	input  logic         en,
	input  cordic_lane_t lane,
	output cordic_lane_t lane_q
);

	cordic_lane_t nxt;

	// rotate toward zero residual angle
	always_comb begin
		nxt.neg = lane.neg;
		if (!lane.m[ANGLE_W-1]) begin
			nxt.x = lane.x - (lane.y >>> STAGE);
			nxt.y = lane.y + (lane.x >>> STAGE);
			nxt.m = lane.m - atan_deg(STAGE);
		end else begin
			nxt.x = lane.x + (lane.y >>> STAGE);
			nxt.y = lane.y - (lane.x >>> STAGE);
			nxt.m = lane.m + atan_deg(STAGE);
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			lane_q <= nxt;
	end

endmodule

// ----- sv/orthographic_projection.sv -----
`timescale 1ns / 1ps
// Stages: widen, reduce, CORDIC cells, first and second products, scale, output.
// One item per cycle unless stalled; three CORDIC rows of 20 cells run side by side.
// The whole pipeline stalls together only while the output register is full and unread.
// Reset clears the valid pipeline and loads view 0/0, scale 1.0 and no flip.
// ----------------------------------------------------------------------------
// orthographic_projection: orthographic map projection
// Projects latitude/longitude about a configured view centre to plot
// coordinates with a near-hemisphere flag.
// ----------------------------------------------------------------------------
module orthographic_projection
	import orth_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	orth_point_if.sink point,
	orth_proj_if.source proj,
	orth_cfg_if.sink   cfg
);

	localparam int NSTAGE = 2 + CORDIC_N + 3;

	logic signed [23:0] view_lat_q;
	logic signed [24:0] view_lon_q;
	logic [20:0]        scale_q;
	logic               flip_x_q;

	logic              en;
	logic [NSTAGE-1:0] vld_q;
	logic              out_valid_q;

	// register writes
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_lat_q <= '0;
			view_lon_q <= '0;
			scale_q    <= SCALE_RESET;
			flip_x_q   <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_VIEW_LAT: view_lat_q <= cfg.data[23:0];
				REG_VIEW_LON: view_lon_q <= cfg.data;
				REG_SCALE:    scale_q    <= cfg.data[20:0];
				REG_FLIP_X:   flip_x_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// global advance
	assign en          = !out_valid_q || proj.ready;
	assign point.ready = en;

	// valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[NSTAGE-2:0], point.valid};
	end

	// widen angles, longitude difference
	logic signed [RED_W-1:0] lat_s1, vlat_s1, dlon_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			lat_s1  <= RED_W'(point.lat) <<< ANG_SHIFT;
			vlat_s1 <= RED_W'(view_lat_q) <<< ANG_SHIFT;
			dlon_s1 <= (RED_W'(point.lon) <<< ANG_SHIFT) - (RED_W'(view_lon_q) <<< ANG_SHIFT);
		end
	end

	// three CORDIC rows: point latitude, view latitude, longitude difference
	logic signed [RED_W-1:0] ang [3];
	cordic_lane_t            lane [3][CORDIC_N+1];
	assign ang[0] = lat_s1;
	assign ang[1] = vlat_s1;
	assign ang[2] = dlon_s1;

	for (genvar r = 0; r < 3; r++) begin : g_row
		orth_reduce u_red (
			.clk    (clk),
			.en     (en),
			.angle  (ang[r]),
			.lane_q (lane[r][0])
		);
		for (genvar c = 0; c < CORDIC_N; c++) begin : g_cell
			orth_cordic_cell #(.STAGE(c)) u_cell (
				.clk    (clk),
				.en     (en),
				.lane   (lane[r][c]),
				.lane_q (lane[r][c+1])
			);
		end
	end

	// sines and cosines with quadrant sign
	logic signed [TRIG_W-1:0] sl, cl, sp, cp, sd, cd;
	always_comb begin
		sl = lane[0][CORDIC_N].neg ? -lane[0][CORDIC_N].y : lane[0][CORDIC_N].y;
		cl = lane[0][CORDIC_N].neg ? -lane[0][CORDIC_N].x : lane[0][CORDIC_N].x;
		sp = lane[1][CORDIC_N].neg ? -lane[1][CORDIC_N].y : lane[1][CORDIC_N].y;
		cp = lane[1][CORDIC_N].neg ? -lane[1][CORDIC_N].x : lane[1][CORDIC_N].x;
		sd = lane[2][CORDIC_N].neg ? -lane[2][CORDIC_N].y : lane[2][CORDIC_N].y;
		cd = lane[2][CORDIC_N].neg ? -lane[2][CORDIC_N].x : lane[2][CORDIC_N].x;
	end

	// first products
	logic signed [TRIG_W-1:0] spsl_s1, cpcl_s1, u_s1, cpsl_s1, spcl_s1, cd_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			spsl_s1 <= mulq(sp, sl);
			cpcl_s1 <= mulq(cp, cl);
			u_s1    <= mulq(cl, sd);
			cpsl_s1 <= mulq(cp, sl);
			spcl_s1 <= mulq(sp, cl);
			cd_s1   <= cd;
		end
	end

	// second products, visibility term
	logic signed [TRIG_W:0]   z_s2, v_s2;
	logic signed [TRIG_W-1:0] u_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			z_s2 <= (TRIG_W+1)'(spsl_s1) + (TRIG_W+1)'(mulq(cpcl_s1, cd_s1));
			v_s2 <= (TRIG_W+1)'(cpsl_s1) - (TRIG_W+1)'(mulq(spcl_s1, cd_s1));
			u_s2 <= u_s1;
		end
	end

	// scale
	logic signed [NUM_W-1:0] su_s3, sv_s3;
	logic                    vis_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			su_s3  <= NUM_W'($signed({1'b0, scale_q}) * u_s2);
			sv_s3  <= NUM_W'($signed({1'b0, scale_q}) * v_s2);
			vis_s3 <= !z_s2[TRIG_W];
		end
	end

	// output register
	logic [OUT_W-1:0] x_q, y_q;
	logic             vis_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= vld_q[NSTAGE-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_q <= vis_s3;
			if (vis_s3) begin
				x_q <= pack_out(flip_x_q ? NUM_ONE - su_s3 : NUM_ONE + su_s3);
				y_q <= pack_out(NUM_ONE - sv_s3);
			end else begin
				x_q <= '0;
				y_q <= '0;
			end
		end
	end

	assign proj.valid   = out_valid_q;
	assign proj.x_pos   = x_q;
	assign proj.y_pos   = y_q;
	assign proj.visible = vis_q;

endmodule

// ----- tb/sv/orth_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orth_checker: projection predictor and result comparison
// Watches the point, projection and register channels, computes the expected
// projection of every accepted point and compares it with each result item.
// ----------------------------------------------------------------------------
module orth_checker
	import orth_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	orth_point_if point,
	orth_proj_if proj,
	orth_cfg_if  cfg,
	output int   fail_count,
	output int   pending
);

	typedef struct {
		logic signed [20:0] x_pos;
		logic signed [20:0] y_pos;
		logic               visible;
	} proj_t;

	proj_t projections_due[$];

	logic signed [23:0] view_lat;
	logic signed [24:0] view_lon;
	logic [20:0]        scale;
	logic               flip_x;

	localparam longint ATAN_TBL [20] = '{
		754974720, 445687602, 235489088, 119537938, 60000934,
		30029717, 15018523, 7509720, 3754917, 1877466,
		938734, 469367, 234684, 117342, 58671,
		29335, 14668, 7334, 3667, 1833};

	// floor shift of a signed value
	function automatic longint shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint q30(longint a, longint b);
		return shr(a * b + (64'sd1 <<< 29), 30);
	endfunction

	// quadrant fold then rotation-mode cordic, q30 outputs
	function automatic void trig(longint a, output longint s, output longint c);
		longint full, half, quarter, m, x, y, nx;
		bit flip;
		full = 64'sd360 <<< 24;
		half = 64'sd180 <<< 24;
		quarter = 64'sd90 <<< 24;
		m = a % full;
		flip = 0;
		if (m < 0) m += full;
		if (m >= half) m -= full;
		if (m > quarter) begin
			m -= half;
			flip = 1;
		end else if (m < -quarter) begin
			m += half;
			flip = 1;
		end
		x = 652032874;
		y = 0;
		for (int i = 0; i < 20; i++) begin
			if (m >= 0) begin
				nx = x - shr(y, i);
				y = y + shr(x, i);
				m -= ATAN_TBL[i];
			end else begin
				nx = x + shr(y, i);
				y = y - shr(x, i);
				m += ATAN_TBL[i];
			end
			x = nx;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic logic signed [20:0] round_sat(longint num);
		longint v;
		v = shr(num + (64'sd1 <<< 30), 31);
		if (v > 1048575) v = 1048575;
		if (v < -1048576) v = -1048576;
		return v[20:0];
	endfunction

	function automatic proj_t project(logic signed [23:0] lat, logic signed [25:0] lon);
		longint s_lat, c_lat, s_v, c_v, s_d, c_d, z, u, v, one;
		proj_t r;
		trig(longint'(lat) <<< 8, s_lat, c_lat);
		trig(longint'(view_lat) <<< 8, s_v, c_v);
		trig((longint'(lon) <<< 8) - (longint'(view_lon) <<< 8), s_d, c_d);
		z = q30(s_v, s_lat) + q30(q30(c_v, c_lat), c_d);
		if (z < 0) begin
			r = '{21'sd0, 21'sd0, 1'b0};
			return r;
		end
		u = q30(c_lat, s_d);
		v = q30(c_v, s_lat) - q30(q30(s_v, c_lat), c_d);
		one = 64'sd1 <<< 46;
		u = longint'({1'b0, scale}) * u;
		v = longint'({1'b0, scale}) * v;
		r.x_pos = round_sat(flip_x ? one - u : one + u);
		r.y_pos = round_sat(one - v);
		r.visible = 1'b1;
		return r;
	endfunction

	assign pending = projections_due.size();

	// register shadow, prediction and comparison
	always @(posedge clk or negedge arst_n) begin
		proj_t want;
		if (!arst_n) begin
			view_lat <= '0;
			view_lon <= '0;
			scale <= SCALE_RESET;
			flip_x <= 1'b0;
			fail_count <= 0;
			projections_due.delete();
		end else begin
			if (point.valid && point.ready)
				projections_due.push_back(project(point.lat, point.lon));
			if (proj.valid && proj.ready) begin
				if (projections_due.size() == 0) begin
					$display("%0t: unexpected item x=%0d y=%0d vis=%0b", $time,
						proj.x_pos, proj.y_pos, proj.visible);
					fail_count <= fail_count + 1;
				end else begin
					want = projections_due.pop_front();
					if (want.x_pos !== proj.x_pos || want.y_pos !== proj.y_pos ||
							want.visible !== proj.visible) begin
						$display("%0t: expected x=%0d y=%0d vis=%0b got x=%0d y=%0d vis=%0b",
							$time, want.x_pos, want.y_pos, want.visible,
							proj.x_pos, proj.y_pos, proj.visible);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_VIEW_LAT: view_lat <= cfg.data[23:0];
					REG_VIEW_LON: view_lon <= cfg.data[24:0];
					REG_SCALE: scale <= cfg.data[20:0];
					REG_FLIP_X: flip_x <= cfg.data[0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: orthographic projection testbench
// Drives directed and random points through several view settings under
// varying idle patterns and back pressure; the checker does the comparison.
// ----------------------------------------------------------------------------
module tb;
	import orth_pkg::*;

	localparam int LATENCY = 26;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count, pending;
	int   src_idle_pct = 0, dst_idle_pct = 0;
	bit   hold_sink = 0;
	longint cycles = 0;

	orth_point_if point();
	orth_proj_if  proj();
	orth_cfg_if   cfg();

	orthographic_projection dut (.clk(clk), .arst_n(arst_n), .point(point), .proj(proj),
		.cfg(cfg));
	orth_checker chk (.clk(clk), .arst_n(arst_n), .point(point), .proj(proj), .cfg(cfg),
		.fail_count(fail_count), .pending(pending));

	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver ready with random stalls
	always @(negedge clk) begin
		if (hold_sink)
			proj.ready <= 1'b0;
		else
			proj.ready <= ($urandom_range(99) >= dst_idle_pct);
	end

	initial begin
		point.valid = 0;
		point.lat = 0;
		point.lon = 0;
		cfg.valid = 0;
		cfg.index = 0;
		cfg.data = 0;
		proj.ready = 0;
	end

	// driven at the falling edge, one write item per call
	task automatic write_reg(logic [7:0] idx, logic [24:0] val);
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data = val;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	task automatic send_point(logic signed [23:0] lat, logic signed [25:0] lon);
		while ($urandom_range(99) < src_idle_pct) begin
			point.valid <= 1'b0;
			@(negedge clk);
		end
		point.valid <= 1'b1;
		point.lat <= lat;
		point.lon <= lon;
		do @(posedge clk); while (!point.ready);
		@(negedge clk);
	endtask

	// wait for all projections then the pipeline depth
	task automatic drain();
		point.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic send_random(int n);
		logic signed [23:0] la;
		logic signed [25:0] lo;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0) begin
				la = $urandom;
				lo = $urandom;
			end else begin
				la = $urandom_range(11796480) - 5898240;
				lo = $urandom_range(47185920) - 23592960;
			end
			send_point(la, lo);
		end
	endtask

	initial begin
		logic signed [23:0] dl [];
		logic signed [25:0] dn [];
		dl = '{0, 5898240, -5898240, 24'sh7fffff, -24'sh800000, 2949120, -2949120,
			0, 0, 0, 0, 0, 5898239, 0, 1, -1};
		dn = '{0, 0, 0, 0, 0, 5898240, -5898240, 5898240, -5898240, 11796480,
			-11796480, 23592960, 0, 26'sh1ffffff, -26'sh2000000, 2};
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed points at default view, horizon and far side included
		for (int i = 0; i < dl.size(); i++) send_point(dl[i], dn[i]);
		drain();

		// extreme view and scale, flip on
		write_reg(REG_VIEW_LAT, 25'(24'sd5898240));
		write_reg(REG_VIEW_LON, 25'sh1ffffff & 25'(-25'sd11796480));
		write_reg(REG_SCALE, 25'd1048576);
		write_reg(REG_FLIP_X, 25'd1);
		write_reg(8'd9, 25'd123);
		for (int i = 0; i < dl.size(); i++) send_point(dl[i], dn[i]);
		send_random(40);
		drain();

		// sender idles lightly, receiver heavily
		src_idle_pct = 17;
		dst_idle_pct = 80;
		write_reg(REG_VIEW_LAT, 25'(-24'sd5898240));
		write_reg(REG_VIEW_LON, 25'd11796480);
		write_reg(REG_SCALE, 25'h1fffff);
		write_reg(REG_FLIP_X, 25'd0);
		send_random(180);
		drain();

		// the other way round, random view and extreme out-of-range registers
		src_idle_pct = 80;
		dst_idle_pct = 17;
		write_reg(REG_VIEW_LAT, 25'($urandom_range(11796480) - 5898240));
		write_reg(REG_VIEW_LON, 25'($urandom_range(23592960) - 11796480));
		write_reg(REG_SCALE, 25'd0);
		send_random(60);
		drain();
		write_reg(REG_VIEW_LAT, 25'h0800000);
		write_reg(REG_VIEW_LON, 25'h1000000);
		write_reg(REG_SCALE, 25'($urandom_range(1048576)));
		write_reg(REG_FLIP_X, 25'd1);
		send_random(120);
		drain();

		// no idling, long receiver hold-off so the pipeline backs up
		src_idle_pct = 0;
		dst_idle_pct = 0;
		write_reg(REG_VIEW_LAT, 25'd1000000);
		write_reg(REG_VIEW_LON, 25'(-25'sd3000000));
		write_reg(REG_SCALE, 25'd65536);
		write_reg(REG_FLIP_X, 25'd0);
		fork
			begin
				hold_sink = 1;
				repeat (200) @(negedge clk);
				hold_sink = 0;
			end
			send_random(200);
		join
		drain();

		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/orth_pkg.sv
sv/orth_ifs.sv
sv/orth_reduce.sv
sv/orth_cordic_cell.sv
sv/orthographic_projection.sv
tb/sv/orth_checker.sv
tb/sv/tb.sv
